@@ design/mrlh_pkg.sv @@
// ----------------------------------------------------------------------------
// Masked region level histogram package
// Shared widths, codes, types and a helper function of the histogram block.
// ----------------------------------------------------------------------------
package mrlh_pkg;

  localparam int LEVEL_W     = 8;
  localparam int LABEL_W     = 4;
  localparam int IDX_W       = 3;
  localparam int SHARE_W     = 17;
  localparam int PIXELS_W    = 20;
  localparam int CFG_W       = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 4;

  localparam int DEF_MAX_BINS    = 8;
  localparam int DEF_MAX_REGIONS = 8;
  localparam int DEF_COUNT_BITS  = 20;

  localparam logic [CFG_W-1:0]     CFG_RESET       = 4'd8;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_BINS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_REGIONS = 2'd1;

  localparam logic [SHARE_W-1:0] SHARE_ONE = 17'h10000;

  typedef struct packed {
    logic [IDX_W-1:0] region;
    logic [IDX_W-1:0] bin;
    logic             count;
    logic             last;
    logic [CFG_W-1:0] nb;
    logic [CFG_W-1:0] nr;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_COUNT,
    ST_DRAIN,
    ST_READ,
    ST_LOAD,
    ST_DIVIDE,
    ST_PUT
  } back_state_t;

  function automatic int idx_w(input int n);
    return (n <= 1) ? 1 : $clog2(n);
  endfunction

endpackage

@@ design/mrlh_if.sv @@
// ----------------------------------------------------------------------------
// Masked region level histogram channels
// Pixel input channel and histogram result channel with valid and ready.
// ----------------------------------------------------------------------------
interface mrlh_in_if;
  logic                         valid;
  logic                         ready;
  logic [mrlh_pkg::LEVEL_W-1:0] motion_level;
  logic [mrlh_pkg::LABEL_W-1:0] region_label;
  logic                         last_pixel;

  modport source (output valid, motion_level, region_label, last_pixel, input ready);
  modport sink (input valid, motion_level, region_label, last_pixel, output ready);
endinterface

interface mrlh_out_if;
  logic                          valid;
  logic                          ready;
  logic [mrlh_pkg::IDX_W-1:0]    region_index;
  logic [mrlh_pkg::IDX_W-1:0]    bin_index;
  logic [mrlh_pkg::SHARE_W-1:0]  bin_share;
  logic [mrlh_pkg::PIXELS_W-1:0] region_pixels;
  logic                          last_result;

  modport source (output valid, region_index, bin_index, bin_share, region_pixels,
                  last_result, input ready);
  modport sink (input valid, region_index, bin_index, bin_share, region_pixels,
                last_result, output ready);
endinterface

@@ design/mrlh_front.sv @@
// ----------------------------------------------------------------------------
// Masked region level histogram front end
// Holds the configuration, accepts pixels and turns each into a queued command.
// ----------------------------------------------------------------------------
module mrlh_front #(
  parameter int MAX_BINS    = mrlh_pkg::DEF_MAX_BINS,
  parameter int MAX_REGIONS = mrlh_pkg::DEF_MAX_REGIONS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [mrlh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mrlh_pkg::CFG_W-1:0]     cfg_wdata,
  mrlh_in_if.sink                        in_chan,
  input  logic                           q_full,
  output logic                           q_push,
  output mrlh_pkg::cmd_t                 q_data
);

  localparam int PROD_W = mrlh_pkg::LEVEL_W + mrlh_pkg::CFG_W;

  logic [mrlh_pkg::CFG_W-1:0] bins_r;
  logic [mrlh_pkg::CFG_W-1:0] regions_r;
  logic [mrlh_pkg::CFG_W-1:0] nb_eff;
  logic [mrlh_pkg::CFG_W-1:0] nr_eff;
  logic [PROD_W-1:0]          prod;
  logic [mrlh_pkg::LABEL_W-1:0] label_m1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bins_r    <= mrlh_pkg::CFG_RESET;
      regions_r <= mrlh_pkg::CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mrlh_pkg::CFG_IDX_BINS:    bins_r    <= cfg_wdata;
        mrlh_pkg::CFG_IDX_REGIONS: regions_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (bins_r == '0) begin
      nb_eff = mrlh_pkg::CFG_W'(1);
    end else if (bins_r > mrlh_pkg::CFG_W'(MAX_BINS)) begin
      nb_eff = mrlh_pkg::CFG_W'(MAX_BINS);
    end else begin
      nb_eff = bins_r;
    end
    if (regions_r == '0) begin
      nr_eff = mrlh_pkg::CFG_W'(1);
    end else if (regions_r > mrlh_pkg::CFG_W'(MAX_REGIONS)) begin
      nr_eff = mrlh_pkg::CFG_W'(MAX_REGIONS);
    end else begin
      nr_eff = regions_r;
    end
  end

  always_comb begin
    prod     = PROD_W'(in_chan.motion_level) * PROD_W'(nb_eff);
    label_m1 = in_chan.region_label - mrlh_pkg::LABEL_W'(1);
    q_data.region = mrlh_pkg::IDX_W'(label_m1);
    q_data.bin    = mrlh_pkg::IDX_W'(prod >> mrlh_pkg::LEVEL_W);
    q_data.count  = (in_chan.region_label != '0) &&
                    (in_chan.region_label <= mrlh_pkg::LABEL_W'(nr_eff));
    q_data.last   = in_chan.last_pixel;
    q_data.nb     = nb_eff;
    q_data.nr     = nr_eff;
  end

  assign in_chan.ready = !q_full;
  assign q_push        = in_chan.valid && !q_full;

endmodule

@@ design/mrlh_fifo.sv @@
// ----------------------------------------------------------------------------
// Masked region level histogram command queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module mrlh_fifo #(
  parameter int DEPTH = mrlh_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mrlh_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output mrlh_pkg::cmd_t pop_data,
  output logic           not_empty
);

  localparam int AW = mrlh_pkg::idx_w(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  mrlh_pkg::cmd_t slot_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r;
  logic [AW-1:0]  rd_ptr_r;
  logic [CW-1:0]  fill_r;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        fill_r <= fill_r + CW'(1);
      end else if (pop && !push) begin
        fill_r <= fill_r - CW'(1);
      end
    end
  end

  assign full      = (fill_r == CW'(DEPTH));
  assign not_empty = (fill_r != '0);
  assign pop_data  = slot_r[rd_ptr_r];

endmodule

@@ design/mrlh_div.sv @@
// ----------------------------------------------------------------------------
// Masked region level histogram share divider
// Restoring divider giving one quotient bit of count * 65536 / total a cycle.
// ----------------------------------------------------------------------------
module mrlh_div #(
  parameter int COUNT_BITS = mrlh_pkg::DEF_COUNT_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [COUNT_BITS-1:0]        dividend,
  input  logic [COUNT_BITS-1:0]        divisor,
  output logic                         done,
  output logic [mrlh_pkg::SHARE_W-1:0] quotient
);

  localparam int SW = mrlh_pkg::idx_w(mrlh_pkg::SHARE_W);

  logic [COUNT_BITS:0]            rem_r;
  logic [COUNT_BITS-1:0]          den_r;
  logic [mrlh_pkg::SHARE_W-1:0]   q_r;
  logic [SW-1:0]                  step_r;
  logic                           busy_r;
  logic                           done_r;
  logic                           ge;
  logic [COUNT_BITS-1:0]          diff;

  always_comb begin
    ge   = rem_r >= {1'b0, den_r};
    diff = ge ? COUNT_BITS'(rem_r - {1'b0, den_r}) : rem_r[COUNT_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= SW'(mrlh_pkg::SHARE_W - 1);
      end else if (busy_r) begin
        step_r <= step_r - SW'(1);
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, dividend};
      den_r <= divisor;
    end else if (busy_r) begin
      rem_r <= {diff, 1'b0};
      q_r   <= {q_r[mrlh_pkg::SHARE_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

@@ design/mrlh_back.sv @@
// ----------------------------------------------------------------------------
// Masked region level histogram back end
// Counts queued pixels into the histogram memory and emits normalised shares.
// ----------------------------------------------------------------------------
module mrlh_back #(
  parameter int MAX_BINS    = mrlh_pkg::DEF_MAX_BINS,
  parameter int MAX_REGIONS = mrlh_pkg::DEF_MAX_REGIONS,
  parameter int COUNT_BITS  = mrlh_pkg::DEF_COUNT_BITS
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  mrlh_pkg::cmd_t q_data,
  output logic           q_pop,
  mrlh_out_if.source     out_chan
);

  localparam int DEPTH = MAX_REGIONS * MAX_BINS;
  localparam int AW    = mrlh_pkg::idx_w(DEPTH);
  localparam int RW    = mrlh_pkg::idx_w(MAX_REGIONS);
  localparam int CW    = mrlh_pkg::CFG_W;

  mrlh_pkg::back_state_t state_r;
  mrlh_pkg::back_state_t state_nxt;

  logic [COUNT_BITS-1:0] mem [DEPTH];
  logic [COUNT_BITS-1:0] mem_q_r;
  logic                  vldq_r;
  logic [DEPTH-1:0]      vld_r;
  logic [COUNT_BITS-1:0] rc_r [MAX_REGIONS];

  logic                  b_valid_r;
  logic                  b_count_r;
  logic [AW-1:0]         b_addr_r;
  logic [RW-1:0]         b_reg_r;
  logic                  pw_en_r;
  logic [AW-1:0]         pw_addr_r;
  logic [COUNT_BITS-1:0] pw_val_r;

  logic [mrlh_pkg::IDX_W-1:0] er_r;
  logic [mrlh_pkg::IDX_W-1:0] eb_r;
  logic [CW-1:0]              nb_r;
  logic [CW-1:0]              nr_r;

  logic                          out_valid_r;
  logic [mrlh_pkg::IDX_W-1:0]    out_region_r;
  logic [mrlh_pkg::IDX_W-1:0]    out_bin_r;
  logic [mrlh_pkg::SHARE_W-1:0]  out_share_r;
  logic [mrlh_pkg::PIXELS_W-1:0] out_pixels_r;
  logic                          out_last_r;

  logic [AW-1:0]                rd_addr;
  logic                         div_start;
  logic                         div_done;
  logic [mrlh_pkg::SHARE_W-1:0] div_q;
  logic                         put;
  logic                         emit_final;
  logic [COUNT_BITS-1:0]        b_cur;
  logic [COUNT_BITS-1:0]        b_inc;
  logic                         b_we;
  logic [RW-1:0]                rc_addr;
  logic [COUNT_BITS-1:0]        rc_cur;
  logic [COUNT_BITS-1:0]        bc_rd;

  function automatic logic [AW-1:0] addr_of(input logic [mrlh_pkg::IDX_W-1:0] reg_i,
                                            input logic [mrlh_pkg::IDX_W-1:0] bin_i);
    return AW'(int'(reg_i) * MAX_BINS + int'(bin_i));
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v == '1) ? v : v + COUNT_BITS'(1);
  endfunction

  mrlh_div #(
    .COUNT_BITS (COUNT_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (bc_rd),
    .divisor  (rc_cur),
    .done     (div_done),
    .quotient (div_q)
  );

  assign emit_final = (CW'(er_r) == nr_r - CW'(1)) && (CW'(eb_r) == nb_r - CW'(1));
  assign bc_rd      = vldq_r ? mem_q_r : '0;
  assign rc_addr    = b_valid_r ? b_reg_r : er_r[RW-1:0];
  assign rc_cur     = rc_r[rc_addr];

  always_comb begin
    if (pw_en_r && (pw_addr_r == b_addr_r)) begin
      b_cur = pw_val_r;
    end else begin
      b_cur = bc_rd;
    end
    b_inc = sat_inc(b_cur);
    b_we  = b_valid_r && b_count_r;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mrlh_pkg::ST_COUNT: begin
        if (q_valid && q_data.last) begin
          state_nxt = mrlh_pkg::ST_DRAIN;
        end
      end
      mrlh_pkg::ST_DRAIN:  state_nxt = mrlh_pkg::ST_READ;
      mrlh_pkg::ST_READ:   state_nxt = mrlh_pkg::ST_LOAD;
      mrlh_pkg::ST_LOAD:   state_nxt = mrlh_pkg::ST_DIVIDE;
      mrlh_pkg::ST_DIVIDE: begin
        if (div_done) begin
          state_nxt = mrlh_pkg::ST_PUT;
        end
      end
      mrlh_pkg::ST_PUT: begin
        if (!out_valid_r || out_chan.ready) begin
          state_nxt = emit_final ? mrlh_pkg::ST_COUNT : mrlh_pkg::ST_READ;
        end
      end
      default: state_nxt = mrlh_pkg::ST_COUNT;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    div_start = 1'b0;
    put       = 1'b0;
    rd_addr   = addr_of(er_r, eb_r);
    unique case (state_r)
      mrlh_pkg::ST_COUNT: begin
        q_pop   = q_valid;
        rd_addr = addr_of(q_data.region, q_data.bin);
      end
      mrlh_pkg::ST_LOAD:  div_start = 1'b1;
      mrlh_pkg::ST_PUT:   put = !out_valid_r || out_chan.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mrlh_pkg::ST_COUNT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      mem[b_addr_r] <= b_inc;
    end
    mem_q_r   <= mem[rd_addr];
    vldq_r    <= vld_r[rd_addr];
    b_addr_r  <= addr_of(q_data.region, q_data.bin);
    b_reg_r   <= RW'(q_data.region);
    b_count_r <= q_data.count;
    pw_addr_r <= b_addr_r;
    pw_val_r  <= b_inc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      b_valid_r <= 1'b0;
      pw_en_r   <= 1'b0;
      for (int i = 0; i < MAX_REGIONS; i++) begin
        rc_r[i] <= '0;
      end
    end else begin
      b_valid_r <= q_pop;
      pw_en_r   <= b_we;
      if (b_we) begin
        vld_r[b_addr_r] <= 1'b1;
        rc_r[b_reg_r]   <= sat_inc(rc_cur);
      end
      if (put && emit_final) begin
        vld_r <= '0;
        for (int i = 0; i < MAX_REGIONS; i++) begin
          rc_r[i] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      er_r <= '0;
      eb_r <= '0;
      nb_r <= mrlh_pkg::CFG_RESET;
      nr_r <= mrlh_pkg::CFG_RESET;
    end else if (q_pop && q_data.last) begin
      er_r <= '0;
      eb_r <= '0;
      nb_r <= q_data.nb;
      nr_r <= q_data.nr;
    end else if (put && !emit_final) begin
      if (CW'(eb_r) == nb_r - CW'(1)) begin
        eb_r <= '0;
        er_r <= er_r + mrlh_pkg::IDX_W'(1);
      end else begin
        eb_r <= eb_r + mrlh_pkg::IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (put) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (put) begin
      out_region_r <= er_r;
      out_bin_r    <= eb_r;
      out_share_r  <= (rc_cur == '0) ? '0 : div_q;
      out_pixels_r <= mrlh_pkg::PIXELS_W'(rc_cur);
      out_last_r   <= emit_final;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.region_index  = out_region_r;
  assign out_chan.bin_index     = out_bin_r;
  assign out_chan.bin_share     = out_share_r;
  assign out_chan.region_pixels = out_pixels_r;
  assign out_chan.last_result   = out_last_r;

  a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    put && emit_final |=> vld_r == '0 && state_r == mrlh_pkg::ST_COUNT)
    else $error("Histogram store not cleared after the final result.");

  a_share_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    put |-> rc_cur == '0 || div_q <= mrlh_pkg::SHARE_ONE)
    else $error("Bin share exceeds the whole region.");

  a_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == mrlh_pkg::ST_DIVIDE)
    else $error("Divider finished outside the divide phase.");

  a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mrlh_pkg::ST_PUT |-> CW'(er_r) < nr_r && CW'(eb_r) < nb_r)
    else $error("Emit index beyond the regions or bins in use.");

endmodule

@@ design/masked_region_level_histogram.sv @@
// Flow: a pixel is queued, popped by the back end, staged in registers and counted into
// the histogram memory. After a frame's final pixel the back end drains and then passes
// the read, load, divide and put states once per result. Throughput: one pixel per cycle
// while counting; results wait on the receiver and on the bit-serial share divider (one
// quotient bit a cycle). Reset: synchronous and active low; the histogram memory reads
// as empty at once through per-entry valid bits, so no clearing pass follows reset.
// ----------------------------------------------------------------------------
// Masked region level histogram
// Builds per-region level histograms over a frame and emits normalised shares.
// ----------------------------------------------------------------------------
module masked_region_level_histogram #(
  parameter int MAX_BINS    = mrlh_pkg::DEF_MAX_BINS,
  parameter int MAX_REGIONS = mrlh_pkg::DEF_MAX_REGIONS,
  parameter int COUNT_BITS  = mrlh_pkg::DEF_COUNT_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [mrlh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mrlh_pkg::CFG_W-1:0]     cfg_wdata,
  mrlh_in_if.sink                        in_chan,
  mrlh_out_if.source                     out_chan
);

  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_not_empty;
  mrlh_pkg::cmd_t q_in;
  mrlh_pkg::cmd_t q_out;

  mrlh_front #(
    .MAX_BINS    (MAX_BINS),
    .MAX_REGIONS (MAX_REGIONS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_chan),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_in)
  );

  mrlh_fifo #(
    .DEPTH (mrlh_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .not_empty (q_not_empty)
  );

  mrlh_back #(
    .MAX_BINS    (MAX_BINS),
    .MAX_REGIONS (MAX_REGIONS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_not_empty),
    .q_data   (q_out),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

endmodule

@@ sim/tb_masked_region_level_histogram.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Masked region level histogram testbench
// Streams framed pixels through the histogram block under random handshake
// idling and register settings. A local model of the per-region counters
// predicts every normalised bin share, which is checked against the result
// channel in order.
// ----------------------------------------------------------------------------
module tb_masked_region_level_histogram;

  localparam int MAX_BINS      = mrlh_pkg::DEF_MAX_BINS;
  localparam int MAX_REGIONS   = mrlh_pkg::DEF_MAX_REGIONS;
  localparam int COUNT_BITS    = mrlh_pkg::DEF_COUNT_BITS;
  localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_BITS) - 64'd1;
  localparam int RANDOM_PIXELS = 200;
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_LEN      = 600;
  localparam int CYCLE_LIMIT   = 4_000_000;

  localparam logic [mrlh_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
  localparam logic [mrlh_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 2'd3;

  typedef struct packed {
    logic [mrlh_pkg::LEVEL_W-1:0] level;
    logic [mrlh_pkg::LABEL_W-1:0] label;
    logic                         last;
  } pixel_t;

  typedef struct packed {
    logic [mrlh_pkg::IDX_W-1:0]    region;
    logic [mrlh_pkg::IDX_W-1:0]    bin;
    logic [mrlh_pkg::SHARE_W-1:0]  share;
    logic [mrlh_pkg::PIXELS_W-1:0] pixels;
    logic                          last;
  } share_rec_t;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [mrlh_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [mrlh_pkg::CFG_W-1:0]     cfg_wdata;

  mrlh_in_if  pix_if ();
  mrlh_out_if res_if ();

  masked_region_level_histogram dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_chan  (pix_if),
    .out_chan (res_if)
  );

  pixel_t     pixel_q[$];
  share_rec_t share_exp_q[$];
  pixel_t     pix_cur;
  share_rec_t share_got;
  share_rec_t share_want;

  logic [mrlh_pkg::CFG_W-1:0] bins_setting;
  logic [mrlh_pkg::CFG_W-1:0] regions_setting;
  longint unsigned            bin_tally[MAX_REGIONS*MAX_BINS];
  longint unsigned            region_tally[MAX_REGIONS];

  bit steady_in;
  bit steady_out;
  bit hold_req;
  int hold_left;
  int in_wait;
  int out_wait;
  int mismatches;
  int pixels_taken;
  int frames_closed;
  int results_seen;
  int settings_written;
  int random_pixels;
  int cycle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int clamp_setting(input logic [mrlh_pkg::CFG_W-1:0] v, input int hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] %s", $realtime, what);
  endtask

  // Counts one accepted pixel and, on the frame's final pixel, queues the
  // expected shares of every region and bin in use, then clears the counters.
  task automatic tally_pixel(input pixel_t p);
    int nb;
    int nr;
    int rg;
    int bin;
    longint unsigned bc;
    longint unsigned rc;
    longint unsigned share;
    share_rec_t rec;
    nb = clamp_setting(bins_setting, MAX_BINS);
    nr = clamp_setting(regions_setting, MAX_REGIONS);
    if (p.label != 0 && p.label <= nr) begin
      rg  = p.label - 1;
      bin = (int'(p.level) * nb) >> 8;
      if (bin >= nb) bin = nb - 1;
      if (bin_tally[rg*MAX_BINS+bin] < COUNT_MAX) bin_tally[rg*MAX_BINS+bin]++;
      if (region_tally[rg] < COUNT_MAX) region_tally[rg]++;
    end
    if (p.last) begin
      frames_closed++;
      for (rg = 0; rg < nr; rg++) begin
        rc = region_tally[rg];
        for (bin = 0; bin < nb; bin++) begin
          bc    = bin_tally[rg*MAX_BINS+bin];
          share = (rc == 0) ? 0 : (bc << 16) / rc;
          if (share > 65536) share = 65536;
          rec.region = mrlh_pkg::IDX_W'(rg);
          rec.bin    = mrlh_pkg::IDX_W'(bin);
          rec.share  = mrlh_pkg::SHARE_W'(share);
          rec.pixels = mrlh_pkg::PIXELS_W'(rc);
          rec.last   = (rg == nr - 1) && (bin == nb - 1);
          share_exp_q.push_back(rec);
        end
      end
      foreach (bin_tally[i]) bin_tally[i] = 0;
      foreach (region_tally[i]) region_tally[i] = 0;
    end
  endtask

  // Pixel driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      pix_if.valid <= 1'b0;
      in_wait = 0;
    end else begin
      if (pix_if.valid && pix_if.ready) begin
        tally_pixel(pix_cur);
        pixels_taken++;
        in_wait = steady_in ? 0 : $urandom_range(0, 4);
      end
      if (!pix_if.valid || pix_if.ready) begin
        if (in_wait > 0) begin
          in_wait--;
          pix_if.valid <= 1'b0;
        end else if (pixel_q.size() != 0) begin
          pix_cur = pixel_q.pop_front();
          pix_if.motion_level <= pix_cur.level;
          pix_if.region_label <= pix_cur.label;
          pix_if.last_pixel   <= pix_cur.last;
          pix_if.valid        <= 1'b1;
        end else begin
          pix_if.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted down on its own.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left <= HOLD_LEN;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result monitor and checker.
  always @(posedge clk) begin
    if (!rst_n) begin
      res_if.ready <= 1'b0;
      out_wait = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        results_seen++;
        share_got.region = res_if.region_index;
        share_got.bin    = res_if.bin_index;
        share_got.share  = res_if.bin_share;
        share_got.pixels = res_if.region_pixels;
        share_got.last   = res_if.last_result;
        if (share_exp_q.size() == 0) begin
          note_mismatch($sformatf("unexpected result region %0d bin %0d share %0d pixels %0d",
                                  share_got.region, share_got.bin, share_got.share,
                                  share_got.pixels));
        end else begin
          share_want = share_exp_q.pop_front();
          if (share_got !== share_want)
            note_mismatch($sformatf({"result mismatch: region %0d/%0d bin %0d/%0d ",
                                     "share %0d/%0d pixels %0d/%0d last %0d/%0d ",
                                     "(expected/actual)"},
                                    share_want.region, share_got.region,
                                    share_want.bin, share_got.bin,
                                    share_want.share, share_got.share,
                                    share_want.pixels, share_got.pixels,
                                    share_want.last, share_got.last));
        end
        out_wait = steady_out ? 0 : $urandom_range(0, 4);
      end
      if (hold_left != 0) begin
        res_if.ready <= 1'b0;
      end else if (out_wait > 0) begin
        out_wait--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.",
               cycle_count, share_exp_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_setting(input logic [mrlh_pkg::CFG_IDX_W-1:0] idx,
                               input logic [mrlh_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == mrlh_pkg::CFG_IDX_BINS) bins_setting = val;
    else if (idx == mrlh_pkg::CFG_IDX_REGIONS) regions_setting = val;
    settings_written++;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pixel_q.size() != 0 || pix_if.valid || share_exp_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic push_pixel(input int level, input int label, input bit last);
    pixel_t p;
    p.level = mrlh_pkg::LEVEL_W'(level);
    p.label = mrlh_pkg::LABEL_W'(label);
    p.last  = last;
    pixel_q.push_back(p);
  endtask

  function automatic logic [mrlh_pkg::CFG_W-1:0] pick_setting();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return mrlh_pkg::CFG_W'($urandom_range(9, 15));
      2:       return mrlh_pkg::CFG_W'(8);
      3:       return mrlh_pkg::CFG_W'(1);
      default: return mrlh_pkg::CFG_W'($urandom_range(1, 8));
    endcase
  endfunction

  task automatic queue_random_frame();
    int len;
    int nr;
    int level;
    int label;
    nr  = clamp_setting(regions_setting, MAX_REGIONS);
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 5))
        0:       level = 0;
        1:       level = 255;
        2:       level = $urandom_range(0, 7) * 32 + ($urandom_range(0, 1) ? 31 : 0);
        default: level = $urandom_range(0, 255);
      endcase
      case ($urandom_range(0, 9))
        0:       label = 0;
        1:       label = $urandom_range(0, 15);
        default: label = $urandom_range(1, nr);
      endcase
      push_pixel(level, label, i == len - 1);
    end
    random_pixels += len;
  endtask

  initial begin
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_wdata           = '0;
    pix_if.valid        = 1'b0;
    pix_if.motion_level = '0;
    pix_if.region_label = '0;
    pix_if.last_pixel   = 1'b0;
    res_if.ready        = 1'b0;
    bins_setting        = mrlh_pkg::CFG_RESET;
    regions_setting     = mrlh_pkg::CFG_RESET;
    foreach (bin_tally[i]) bin_tally[i] = 0;
    foreach (region_tally[i]) region_tally[i] = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: extremes of level, outside and unused labels, empty
    // regions, and a frame closed by an ignored pixel.
    push_pixel(0, 1, 0);
    push_pixel(255, 8, 0);
    push_pixel(31, 2, 0);
    push_pixel(32, 2, 0);
    push_pixel(127, 3, 0);
    push_pixel(128, 3, 0);
    push_pixel(200, 0, 0);
    push_pixel(77, 9, 0);
    push_pixel(90, 15, 0);
    push_pixel(255, 1, 0);
    push_pixel(5, 0, 1);
    push_pixel(64, 5, 1);
    wait_idle();

    write_setting(CFG_IDX_SPARE_A, 4'd1);
    write_setting(CFG_IDX_SPARE_B, 4'd1);
    write_setting(mrlh_pkg::CFG_IDX_BINS, 4'd1);
    write_setting(mrlh_pkg::CFG_IDX_REGIONS, 4'd1);
    push_pixel(255, 1, 0);
    push_pixel(0, 2, 0);
    push_pixel(128, 1, 1);
    wait_idle();

    write_setting(mrlh_pkg::CFG_IDX_BINS, 4'd0);
    write_setting(mrlh_pkg::CFG_IDX_REGIONS, 4'd15);
    push_pixel(200, 8, 0);
    push_pixel(17, 3, 1);
    wait_idle();

    write_setting(mrlh_pkg::CFG_IDX_BINS, 4'd15);
    write_setting(mrlh_pkg::CFG_IDX_REGIONS, 4'd0);
    push_pixel(255, 1, 0);
    push_pixel(40, 2, 1);
    wait_idle();

    // The bin count changes in the middle of a frame.
    write_setting(mrlh_pkg::CFG_IDX_BINS, 4'd4);
    write_setting(mrlh_pkg::CFG_IDX_REGIONS, 4'd3);
    push_pixel(255, 1, 0);
    push_pixel(64, 2, 0);
    push_pixel(191, 3, 0);
    wait_idle();
    write_setting(mrlh_pkg::CFG_IDX_BINS, 4'd2);
    push_pixel(128, 1, 0);
    push_pixel(10, 3, 0);
    push_pixel(255, 2, 1);
    wait_idle();

    // A frame at full rate, with one region far fuller than the other.
    write_setting(mrlh_pkg::CFG_IDX_BINS, 4'd8);
    write_setting(mrlh_pkg::CFG_IDX_REGIONS, 4'd2);
    steady_in = 1'b1;
    for (int i = 0; i < 5; i++) push_pixel(0, 1, 0);
    push_pixel(100, 2, 0);
    for (int i = 0; i < 12; i++) push_pixel(255, 1, i == 11);
    wait_idle();

    // The receiver stops while two frames are offered back to back.
    write_setting(mrlh_pkg::CFG_IDX_REGIONS, 4'd8);
    hold_req = 1'b1;
    @(negedge clk);
    for (int i = 0; i < 6; i++) push_pixel($urandom_range(0, 255), $urandom_range(1, 8), i == 5);
    for (int i = 0; i < 20; i++) push_pixel($urandom_range(0, 255), $urandom_range(0, 8), i == 19);
    wait_idle();

    while (random_pixels < RANDOM_PIXELS) begin
      write_setting(mrlh_pkg::CFG_IDX_BINS, pick_setting());
      write_setting(mrlh_pkg::CFG_IDX_REGIONS, pick_setting());
      steady_in  = ($urandom_range(0, 3) == 0);
      steady_out = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(2, 5)) queue_random_frame();
      wait_idle();
    end

    if (share_exp_q.size() != 0)
      note_mismatch($sformatf("%0d expected results never arrived", share_exp_q.size()));
    $display("Covered %0d pixels in %0d frames over %0d register writes.",
             pixels_taken, frames_closed, settings_written);
    $display("Checked %0d bin shares; %0d mismatches.", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/mrlh_pkg.sv
design/mrlh_if.sv
design/mrlh_front.sv
design/mrlh_fifo.sv
design/mrlh_div.sv
design/mrlh_back.sv
design/masked_region_level_histogram.sv
sim/tb_masked_region_level_histogram.sv
